FILE: hdl/running_mean_confidence_interval_assert.svh
`ifndef RUNNING_MEAN_CONFIDENCE_INTERVAL_ASSERT_SVH
`define RUNNING_MEAN_CONFIDENCE_INTERVAL_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define RMCI_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RMCI_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/rmci_pkg.sv
package rmci_pkg;

  localparam int unsigned Z_FRAC = 16;
  localparam logic [30:0] MAX31 = 31'h7FFF_FFFF;
  localparam logic [19:0] Z_RESET = 20'd128451;

  localparam logic REG_MODE = 1'b0;
  localparam logic REG_Z    = 1'b1;

  typedef enum logic [4:0] {
    OP_IDLE, OP_LOAD, OP_CLEAR, OP_SUM, OP_AREA, OP_SUM_AREA, OP_MEAN_INIT, OP_DIV,
    OP_MEAN_SET, OP_DEV_SQ, OP_DEV_ADD, OP_VAR_INIT, OP_SIG_INIT, OP_SQRT, OP_SIG_SET,
    OP_SIG_SQ, OP_ERR_INIT, OP_ERR_SET, OP_MARGIN, OP_BOUNDS, OP_CNT_INC, OP_OUT
  } dp_op_e;

  typedef struct packed {
    logic restart;
    logic mode;
    logic step_ok;
    logic n_gt2;
    logic var_big;
    logic div_last;
    logic sqrt_last;
  } status_t;

  typedef struct packed {
    logic signed [31:0] mean_value;
    logic [30:0]        std_dev;
    logic [30:0]        std_error;
    logic [30:0]        margin;
    logic signed [31:0] lower_bound;
    logic signed [31:0] upper_bound;
    logic               interval_valid;
  } rsp_t;

endpackage

FILE: hdl/rmci_if.sv
interface rmci_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic signed [31:0] sample_value;
  logic [31:0]        sample_time;
  modport source (output valid, opcode, sample_value, sample_time, input ready);
  modport sink (input valid, opcode, sample_value, sample_time, output ready);
endinterface

interface rmci_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] mean_value;
  logic [30:0]        std_dev;
  logic [30:0]        std_error;
  logic [30:0]        margin;
  logic signed [31:0] lower_bound;
  logic signed [31:0] upper_bound;
  logic               interval_valid;
  modport source (output valid, mean_value, std_dev, std_error, margin, lower_bound,
                  upper_bound, interval_valid, input ready);
  modport sink (input valid, mean_value, std_dev, std_error, margin, lower_bound,
                upper_bound, interval_valid, output ready);
endinterface

interface rmci_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [19:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/rmci_dp.sv
module rmci_dp #(
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rmci_pkg::dp_op_e    op_i,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [19:0]         cfg_data_i,
  input  logic                in_opcode_i,
  input  logic signed [31:0]  in_value_i,
  input  logic [31:0]         in_time_i,
  output rmci_pkg::status_t   status_o,
  output rmci_pkg::rsp_t      rsp_o
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [63:0] VAR_LIMIT = 64'd1 << (62 - FRAC_BITS);

  logic                  mode_q;
  logic [19:0]           z_q;
  logic signed [63:0]    vsum_q;
  logic [63:0]           dsum_q;
  logic [COUNT_BITS-1:0] cnt_q;
  logic [31:0]           last_time_q, origin_q;
  logic signed [31:0]    last_val_q, mean_q, lo_q, hi_q;
  logic [30:0]           sig_q, err_q, marg_q;

  logic                  opc_q;
  logic signed [31:0]    v_q;
  logic [31:0]           t_q;
  logic [63:0]           prod_q, num_q, den_q, sx_q, sr_q, sb_q;
  logic [64:0]           rem_q;
  logic                  neg_q;
  logic [5:0]            iter_q;
  rmci_pkg::rsp_t        rsp_q;

  logic signed [63:0] add_b;
  logic signed [64:0] sum65;
  logic signed [63:0] vsum_sat;
  logic [63:0]        vsum_mag, cnt64;
  logic [31:0]        span;
  logic signed [65:0] area;
  logic signed [31:0] mean_sat;
  logic signed [31:0] dev_val;
  logic signed [32:0] dev;
  logic [31:0]        dev_mag;
  logic [64:0]        dsum65;
  logic [64:0]        rem_sh;
  logic               rem_ge;
  logic [63:0]        trial;
  logic               sq_ge;
  logic [50:0]        mprod;
  logic [34:0]        mshift;
  logic signed [33:0] lo34, hi34;
  logic [61:0]        sig_sq;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] x);
    if (x > 34'sd2147483647) return 32'sh7FFF_FFFF;
    if (x < -34'sd2147483648) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  assign cnt64    = {{(64 - COUNT_BITS){1'b0}}, cnt_q};
  assign add_b    = (op_i == rmci_pkg::OP_SUM) ? {{32{v_q[31]}}, v_q} : prod_q;
  assign sum65    = {vsum_q[63], vsum_q} + {add_b[63], add_b};
  assign vsum_sat = (sum65[64] != sum65[63])
                    ? (sum65[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : sum65[63:0];
  assign vsum_mag = vsum_q[63] ? (64'd0 - vsum_q) : vsum_q;
  assign span     = t_q - origin_q;
  assign area     = $signed({2'b00, t_q - last_time_q}) * $signed({{2{last_val_q[31]}}, last_val_q});

  always_comb begin
    if (neg_q) begin
      mean_sat = (num_q > 64'h8000_0000) ? 32'sh8000_0000 : 32'(64'd0 - num_q);
    end else begin
      mean_sat = (num_q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : num_q[31:0];
    end
  end

  assign dev_val = mode_q ? last_val_q : v_q;
  assign dev     = {dev_val[31], dev_val} - {mean_q[31], mean_q};
  assign dev_mag = dev[32] ? 32'(33'd0 - dev) : dev[31:0];
  assign dsum65  = {1'b0, dsum_q} + {1'b0, prod_q >> FRAC_BITS};

  assign rem_sh = {rem_q[63:0], num_q[63]};
  assign rem_ge = rem_sh >= {1'b0, den_q};
  assign trial  = sr_q + sb_q;
  assign sq_ge  = sx_q >= trial;

  assign sig_sq = sig_q * sig_q;

  assign mprod  = z_q * err_q;
  assign mshift = mprod[50:rmci_pkg::Z_FRAC];
  assign lo34   = {{2{mean_q[31]}}, mean_q} - {3'b000, marg_q};
  assign hi34   = {{2{mean_q[31]}}, mean_q} + {3'b000, marg_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      z_q         <= rmci_pkg::Z_RESET;
      vsum_q      <= '0;
      dsum_q      <= '0;
      cnt_q       <= COUNT_BITS'(1);
      last_time_q <= '0;
      origin_q    <= '0;
      last_val_q  <= '0;
      mean_q      <= '0;
      sig_q       <= '0;
      err_q       <= '0;
      marg_q      <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rmci_pkg::REG_MODE: mode_q <= cfg_data_i[0];
          rmci_pkg::REG_Z:    z_q    <= cfg_data_i;
          default: ;
        endcase
      end
      case (op_i)
        rmci_pkg::OP_CLEAR: begin
          vsum_q      <= '0;
          dsum_q      <= '0;
          cnt_q       <= COUNT_BITS'(1);
          last_time_q <= t_q;
          origin_q    <= t_q;
          last_val_q  <= '0;
          mean_q      <= '0;
          sig_q       <= '0;
          err_q       <= '0;
          marg_q      <= '0;
          lo_q        <= '0;
          hi_q        <= '0;
        end
        rmci_pkg::OP_SUM: vsum_q <= vsum_sat;
        rmci_pkg::OP_SUM_AREA: begin
          vsum_q      <= vsum_sat;
          last_time_q <= t_q;
        end
        rmci_pkg::OP_MEAN_SET: mean_q <= mean_sat;
        rmci_pkg::OP_DEV_ADD:  dsum_q <= dsum65[64] ? '1 : dsum65[63:0];
        rmci_pkg::OP_SIG_INIT: begin
          if (num_q >= VAR_LIMIT) sig_q <= rmci_pkg::MAX31;
        end
        rmci_pkg::OP_SIG_SET: sig_q <= (sr_q > 64'h7FFF_FFFF) ? rmci_pkg::MAX31 : sr_q[30:0];
        rmci_pkg::OP_ERR_SET: err_q <= sr_q[30:0];
        rmci_pkg::OP_MARGIN:  marg_q <= (mshift > 35'h7FFF_FFFF) ? rmci_pkg::MAX31 : mshift[30:0];
        rmci_pkg::OP_BOUNDS: begin
          lo_q <= sat32(lo34);
          hi_q <= sat32(hi34);
        end
        rmci_pkg::OP_CNT_INC: begin
          if (cnt_q < CNT_MAX) cnt_q <= cnt_q + 1'b1;
        end
        rmci_pkg::OP_OUT: begin
          if (!opc_q) last_val_q <= v_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      rmci_pkg::OP_LOAD: begin
        opc_q <= in_opcode_i;
        v_q   <= in_value_i;
        t_q   <= in_time_i;
      end
      rmci_pkg::OP_AREA: prod_q <= area[63:0];
      rmci_pkg::OP_MEAN_INIT: begin
        num_q  <= vsum_mag;
        neg_q  <= vsum_q[63];
        den_q  <= mode_q ? {32'd0, (span == 32'd0) ? 32'd1 : span} : cnt64;
        rem_q  <= '0;
        iter_q <= '0;
      end
      rmci_pkg::OP_DIV: begin
        rem_q  <= rem_ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
        num_q  <= {num_q[62:0], rem_ge};
        iter_q <= iter_q + 1'b1;
      end
      rmci_pkg::OP_DEV_SQ: prod_q <= dev_mag * dev_mag;
      rmci_pkg::OP_VAR_INIT: begin
        num_q  <= dsum_q;
        den_q  <= cnt64 - 64'd1;
        rem_q  <= '0;
        iter_q <= '0;
      end
      rmci_pkg::OP_SIG_INIT: begin
        sx_q   <= num_q << FRAC_BITS;
        sr_q   <= '0;
        sb_q   <= 64'd1 << 62;
        iter_q <= '0;
      end
      rmci_pkg::OP_SQRT: begin
        if (sq_ge) begin
          sx_q <= sx_q - trial;
          sr_q <= (sr_q >> 1) + sb_q;
        end else begin
          sr_q <= sr_q >> 1;
        end
        sb_q   <= sb_q >> 2;
        iter_q <= iter_q + 1'b1;
      end
      rmci_pkg::OP_SIG_SQ: begin
        num_q  <= {2'b00, sig_sq};
        den_q  <= cnt64;
        rem_q  <= '0;
        iter_q <= '0;
      end
      rmci_pkg::OP_ERR_INIT: begin
        sx_q   <= num_q;
        sr_q   <= '0;
        sb_q   <= 64'd1 << 62;
        iter_q <= '0;
      end
      rmci_pkg::OP_OUT: begin
        rsp_q.mean_value     <= mean_q;
        rsp_q.std_dev        <= sig_q;
        rsp_q.std_error      <= err_q;
        rsp_q.margin         <= marg_q;
        rsp_q.lower_bound    <= lo_q;
        rsp_q.upper_bound    <= hi_q;
        rsp_q.interval_valid <= cnt_q > COUNT_BITS'(3);
      end
      default: ;
    endcase
  end

  assign status_o.restart   = opc_q;
  assign status_o.mode      = mode_q;
  assign status_o.step_ok   = t_q > last_time_q;
  assign status_o.n_gt2     = cnt_q > COUNT_BITS'(2);
  assign status_o.var_big   = num_q >= VAR_LIMIT;
  assign status_o.div_last  = iter_q == 6'd63;
  assign status_o.sqrt_last = iter_q[4:0] == 5'd31;
  assign rsp_o = rsp_q;

endmodule

FILE: hdl/rmci_ctrl.sv
module rmci_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  rmci_pkg::status_t status_i,
  output rmci_pkg::dp_op_e  op_o
);

  `include "running_mean_confidence_interval_assert.svh"

  typedef enum logic [21:0] {
    S_IDLE     = 22'h000001,
    S_DECIDE   = 22'h000002,
    S_SUM_AREA = 22'h000004,
    S_MEAN_INIT= 22'h000008,
    S_MEAN_DIV = 22'h000010,
    S_MEAN_SET = 22'h000020,
    S_DEV_SQ   = 22'h000040,
    S_DEV_ADD  = 22'h000080,
    S_VAR_INIT = 22'h000100,
    S_VAR_DIV  = 22'h000200,
    S_SIG_INIT = 22'h000400,
    S_SIG_SQRT = 22'h000800,
    S_SIG_SET  = 22'h001000,
    S_SIG_SQ   = 22'h002000,
    S_ERR_DIV  = 22'h004000,
    S_ERR_INIT = 22'h008000,
    S_ERR_SQRT = 22'h010000,
    S_ERR_SET  = 22'h020000,
    S_MARGIN   = 22'h040000,
    S_BOUNDS   = 22'h080000,
    S_CNT_INC  = 22'h100000,
    S_FINISH   = 22'h200000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = state_q == S_IDLE;

  always_comb begin
    state_d     = state_q;
    op_o        = rmci_pkg::OP_IDLE;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_o    = rmci_pkg::OP_LOAD;
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (status_i.restart) begin
          op_o    = rmci_pkg::OP_CLEAR;
          state_d = S_FINISH;
        end else if (!status_i.mode) begin
          op_o    = rmci_pkg::OP_SUM;
          state_d = S_MEAN_INIT;
        end else if (status_i.step_ok) begin
          op_o    = rmci_pkg::OP_AREA;
          state_d = S_SUM_AREA;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_SUM_AREA: begin
        op_o    = rmci_pkg::OP_SUM_AREA;
        state_d = S_MEAN_INIT;
      end
      S_MEAN_INIT: begin
        op_o    = rmci_pkg::OP_MEAN_INIT;
        state_d = S_MEAN_DIV;
      end
      S_MEAN_DIV: begin
        op_o = rmci_pkg::OP_DIV;
        if (status_i.div_last) state_d = S_MEAN_SET;
      end
      S_MEAN_SET: begin
        op_o    = rmci_pkg::OP_MEAN_SET;
        state_d = S_DEV_SQ;
      end
      S_DEV_SQ: begin
        op_o    = rmci_pkg::OP_DEV_SQ;
        state_d = S_DEV_ADD;
      end
      S_DEV_ADD: begin
        op_o    = rmci_pkg::OP_DEV_ADD;
        state_d = status_i.n_gt2 ? S_VAR_INIT : S_CNT_INC;
      end
      S_VAR_INIT: begin
        op_o    = rmci_pkg::OP_VAR_INIT;
        state_d = S_VAR_DIV;
      end
      S_VAR_DIV: begin
        op_o = rmci_pkg::OP_DIV;
        if (status_i.div_last) state_d = S_SIG_INIT;
      end
      S_SIG_INIT: begin
        op_o    = rmci_pkg::OP_SIG_INIT;
        state_d = status_i.var_big ? S_SIG_SQ : S_SIG_SQRT;
      end
      S_SIG_SQRT: begin
        op_o = rmci_pkg::OP_SQRT;
        if (status_i.sqrt_last) state_d = S_SIG_SET;
      end
      S_SIG_SET: begin
        op_o    = rmci_pkg::OP_SIG_SET;
        state_d = S_SIG_SQ;
      end
      S_SIG_SQ: begin
        op_o    = rmci_pkg::OP_SIG_SQ;
        state_d = S_ERR_DIV;
      end
      S_ERR_DIV: begin
        op_o = rmci_pkg::OP_DIV;
        if (status_i.div_last) state_d = S_ERR_INIT;
      end
      S_ERR_INIT: begin
        op_o    = rmci_pkg::OP_ERR_INIT;
        state_d = S_ERR_SQRT;
      end
      S_ERR_SQRT: begin
        op_o = rmci_pkg::OP_SQRT;
        if (status_i.sqrt_last) state_d = S_ERR_SET;
      end
      S_ERR_SET: begin
        op_o    = rmci_pkg::OP_ERR_SET;
        state_d = S_MARGIN;
      end
      S_MARGIN: begin
        op_o    = rmci_pkg::OP_MARGIN;
        state_d = S_BOUNDS;
      end
      S_BOUNDS: begin
        op_o    = rmci_pkg::OP_BOUNDS;
        state_d = S_CNT_INC;
      end
      S_CNT_INC: begin
        op_o    = rmci_pkg::OP_CNT_INC;
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          op_o        = rmci_pkg::OP_OUT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `RMCI_ASSERT_NXT(a_req_starts, in_valid_i && in_ready_o, state_q == S_DECIDE, "request not started")
  `RMCI_ASSERT_IMP(a_rsp_from_finish, $rose(out_valid_q), $past(state_q == S_FINISH), "stray response")
  `RMCI_ASSERT_NXT(a_div_ends, state_q == S_MEAN_DIV && status_i.div_last, state_q == S_MEAN_SET, "divide overran")

endmodule

FILE: hdl/running_mean_confidence_interval.sv
// Per sample, once more than two samples are in, three radix-2 divides and two square roots
// run on one shared datapath (the first root is skipped when the variance saturates); before
// that, one divide; a restart or a weighted sample whose time did not advance skips them all.
// Throughput: one request at a time; the next request is taken once the result is registered.
// Reset: asynchronous, active low; statistics cleared, count 1, z factor 1.96, mode arithmetic.
module running_mean_confidence_interval #(
  parameter int unsigned FRAC_BITS  = 16,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rmci_in_if.sink     in_i,
  rmci_out_if.source  out_o,
  rmci_cfg_if.sink    cfg_i
);

  rmci_pkg::status_t status;
  rmci_pkg::dp_op_e  op;
  rmci_pkg::rsp_t    rsp;

  assign cfg_i.ready = 1'b1;

  rmci_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .op_o        (op)
  );

  rmci_dp #(
    .FRAC_BITS  (FRAC_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .cfg_we_i    (cfg_i.valid),
    .cfg_idx_i   (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .in_opcode_i (in_i.opcode),
    .in_value_i  (in_i.sample_value),
    .in_time_i   (in_i.sample_time),
    .status_o    (status),
    .rsp_o       (rsp)
  );

  assign out_o.mean_value     = rsp.mean_value;
  assign out_o.std_dev        = rsp.std_dev;
  assign out_o.std_error      = rsp.std_error;
  assign out_o.margin         = rsp.margin;
  assign out_o.lower_bound    = rsp.lower_bound;
  assign out_o.upper_bound    = rsp.upper_bound;
  assign out_o.interval_valid = rsp.interval_valid;

endmodule
